// File: rtl/core/kmp_substring_search_defines.svh
// ----------------------------------------------------------------------------
// kmp_substring_search_defines
// Assertion macros shared by the substring search RTL.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_SEARCH_DEFINES_SVH
`define KMP_SUBSTRING_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KMP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("kmp assertion failed");
`define KMP_ASSERT_IMPL(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("kmp assertion failed");
`else
`define KMP_ASSERT(lbl, prop)
`define KMP_ASSERT_IMPL(lbl, cond, expr)
`endif
`endif

// File: rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Types, constants and helpers for the substring search block.
// ----------------------------------------------------------------------------
`default_nettype none
package kmp_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int IDX_BITS      = $clog2(MAX_PATTERN);
    localparam int LEN_BITS      = IDX_BITS + 1;
    localparam int POSITION_BITS = 16;
    localparam int MATCH_BITS    = 16;
    localparam int CFG_BITS      = 64;
    localparam int PAT_BITS      = 8 * MAX_PATTERN;

    typedef logic [7:0]          t_byte;
    typedef logic [IDX_BITS-1:0] t_idx;
    typedef logic [LEN_BITS-1:0] t_len;   // also a link plus one: 0 means no link
    typedef logic [PAT_BITS-1:0] t_pattern;

    typedef enum logic [1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic busy;   // failure table being built
        logic clear;  // abort current text
    } t_ctrl;

    function automatic t_byte pat_byte(input t_pattern pat, input t_idx k);
        pat_byte = pat[8*k +: 8];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/kmp_text_if.sv
// ----------------------------------------------------------------------------
// kmp_text_if
// Text word channel: one text byte and its last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface kmp_text_if;
    import kmp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface
`default_nettype wire

// File: rtl/core/kmp_result_if.sv
// ----------------------------------------------------------------------------
// kmp_result_if
// Result word channel: found flag and start offset of the match.
// ----------------------------------------------------------------------------
`default_nettype none
interface kmp_result_if;
    import kmp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [MATCH_BITS-1:0] match_index;

    modport source (output valid, output found, output match_index, input ready);
    modport sink   (input valid, input found, input match_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/kmp_front.sv
// ----------------------------------------------------------------------------
// kmp_front
// Input side: takes text words into a two-entry queue, holds off while the
// failure table is built.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmp_substring_search_defines.svh"
module kmp_front
    import kmp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_ctrl       i_ctrl,
    kmp_text_if.sink    i_text,
    kmp_text_if.source  o_queue
);

    localparam int DEPTH = 2;

    t_byte      r_byte  [DEPTH];
    logic       r_final [DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign i_text.ready    = (r_count != 2'(DEPTH)) && !i_ctrl.busy;
    assign push            = i_text.valid && i_text.ready;
    assign o_queue.valid   = (r_count != 2'd0);
    assign o_queue.text_byte = r_byte[r_rd];
    assign o_queue.is_final  = r_final[r_rd];
    assign pop             = o_queue.valid && o_queue.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_byte[r_wr]  <= i_text.text_byte;
            r_final[r_wr] <= i_text.is_final;
        end
    end

    `KMP_ASSERT(a_no_overflow, r_count <= 2'(DEPTH))
    `KMP_ASSERT_IMPL(a_ptr_track, r_count == 2'd0 || r_count == 2'(DEPTH), r_wr == r_rd)
    `KMP_ASSERT_IMPL(a_empty_while_build, i_ctrl.busy && !i_ctrl.clear, !push)

endmodule
`default_nettype wire

// File: rtl/core/kmp_links.sv
// ----------------------------------------------------------------------------
// kmp_links
// Pattern registers and failure table: rebuilds the optimized table one step
// per cycle after reset and after every write to the pattern or length register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmp_substring_search_defines.svh"
module kmp_links
    import kmp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [CFG_BITS-1:0]  i_cfg_data,
    input  t_idx                i_link_addr,
    output t_len                o_link_data,
    output t_pattern            o_pattern,
    output t_len                o_len,
    output t_ctrl               o_ctrl
);

    logic [CFG_BITS-1:0] r_pat_low;
    logic [CFG_BITS-1:0] r_pat_high;
    t_len                r_len_raw;
    t_len                r_link [MAX_PATTERN];
    logic                r_busy;
    logic                r_clear;
    t_idx                r_bi;
    t_len                r_bjp1;

    t_pattern pat;
    t_len     len;
    t_idx     jm1;
    t_idx     ni;
    t_idx     nj;
    logic     hit;
    logic     done;
    t_idx     rd_addr;
    t_len     rd_data;
    t_len     wr_data;
    logic     cfg_hit;

    assign pat = {r_pat_high[PAT_BITS-CFG_BITS-1:0], r_pat_low};
    assign len = (r_len_raw > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : r_len_raw;

    always_comb begin
        jm1     = IDX_BITS'(r_bjp1 - LEN_BITS'(1));
        ni      = r_bi + IDX_BITS'(1);
        nj      = IDX_BITS'(r_bjp1);
        hit     = (r_bjp1 == '0) || (pat_byte(pat, r_bi) == pat_byte(pat, jm1));
        done    = (LEN_BITS'(r_bi) + LEN_BITS'(1)) >= len;
        rd_addr = r_busy ? (hit ? nj : jm1) : i_link_addr;
        rd_data = (rd_addr == '0) ? '0 : r_link[rd_addr];
        wr_data = (pat_byte(pat, ni) == pat_byte(pat, nj)) ? rd_data
                                                           : r_bjp1 + LEN_BITS'(1);
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN: cfg_hit = 1'b1;
                default:                                cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len_raw  <= '0;
            r_busy     <= 1'b1;
            r_clear    <= 1'b0;
            r_bi       <= '0;
            r_bjp1     <= '0;
        end else begin
            r_clear <= cfg_hit;
            if (cfg_hit) begin
                r_busy <= 1'b1;
                r_bi   <= '0;
                r_bjp1 <= '0;
                unique case (i_cfg_index)
                    CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                    CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                    CFG_PAT_LEN:  r_len_raw  <= i_cfg_data[LEN_BITS-1:0];
                    default:      r_len_raw  <= r_len_raw;
                endcase
            end else if (r_busy) begin
                if (done) begin
                    r_busy <= 1'b0;
                end else if (hit) begin
                    r_bi   <= ni;
                    r_bjp1 <= r_bjp1 + LEN_BITS'(1);
                end else begin
                    r_bjp1 <= rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !cfg_hit && !done && hit) begin
            r_link[ni] <= wr_data;
        end
    end

    assign o_link_data = rd_data;
    assign o_pattern   = pat;
    assign o_len       = len;
    assign o_ctrl      = '{busy: r_busy, clear: r_clear};

    `KMP_ASSERT_IMPL(a_j_below_i, r_busy, r_bjp1 <= LEN_BITS'(r_bi))
    `KMP_ASSERT_IMPL(a_i_in_pattern, r_busy && len != '0, LEN_BITS'(r_bi) < len)

endmodule
`default_nettype wire

// File: rtl/core/kmp_back.sv
// ----------------------------------------------------------------------------
// kmp_back
// Search engine: advances the match length for each queued text word,
// following one failure link per cycle, and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmp_substring_search_defines.svh"
module kmp_back
    import kmp_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  t_ctrl         i_ctrl,
    input  t_pattern      i_pattern,
    input  t_len          i_len,
    input  t_len          i_link_data,
    output t_idx          o_link_addr,
    kmp_text_if.sink      i_queue,
    kmp_result_if.source  o_result
);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                   r_state;
    t_len                     r_jp1;
    t_byte                    r_c;
    logic                     r_last;
    t_len                     r_matched;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_answer;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [MATCH_BITS-1:0]    r_out_index;

    t_state                   n_state;
    t_len                     n_jp1;
    t_byte                    n_c;
    logic                     n_last;
    t_len                     n_matched;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_answer;
    logic                     n_out_valid;
    logic                     n_out_found;
    logic [MATCH_BITS-1:0]    n_out_index;

    logic                     out_free;
    logic                     pop;
    logic                     hit;
    t_idx                     jm1;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] start;

    assign out_free      = !r_out_valid || o_result.ready;
    assign i_queue.ready = (r_state == S_IDLE) && out_free && !i_ctrl.busy;
    assign pop           = i_queue.valid && i_queue.ready;
    assign jm1           = IDX_BITS'(r_jp1 - LEN_BITS'(1));
    assign o_link_addr   = jm1;
    assign hit           = (r_jp1 == '0) || (pat_byte(i_pattern, jm1) == r_c);
    assign pos_inc       = (r_pos == '1) ? r_pos : r_pos + POSITION_BITS'(1);
    assign start         = r_pos + POSITION_BITS'(1) - POSITION_BITS'(i_len);

    always_comb begin
        n_state     = r_state;
        n_jp1       = r_jp1;
        n_c         = r_c;
        n_last      = r_last;
        n_matched   = r_matched;
        n_pos       = r_pos;
        n_answer    = r_answer;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_found = r_out_found;
        n_out_index = r_out_index;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    if (r_answer) begin
                        if (i_queue.is_final) begin
                            n_matched = '0;
                            n_pos     = '0;
                            n_answer  = 1'b0;
                        end
                    end else if (i_len == '0) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b1;
                        n_out_index = MATCH_BITS'(r_pos);
                        if (i_queue.is_final) begin
                            n_matched = '0;
                            n_pos     = '0;
                            n_answer  = 1'b0;
                        end else begin
                            n_answer = 1'b1;
                        end
                    end else begin
                        n_c     = i_queue.text_byte;
                        n_last  = i_queue.is_final;
                        n_jp1   = r_matched + LEN_BITS'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!hit) begin
                    n_jp1 = i_link_data;
                end else begin
                    n_state = S_IDLE;
                    if (r_jp1 >= i_len) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b1;
                        n_out_index = MATCH_BITS'(start);
                        n_matched   = '0;
                        if (r_last) begin
                            n_pos    = '0;
                            n_answer = 1'b0;
                        end else begin
                            n_pos    = pos_inc;
                            n_answer = 1'b1;
                        end
                    end else if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b0;
                        n_out_index = '0;
                        n_matched   = '0;
                        n_pos       = '0;
                        n_answer    = 1'b0;
                    end else begin
                        n_matched = r_jp1;
                        n_pos     = pos_inc;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_matched   <= '0;
            r_pos       <= '0;
            r_answer    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_state     <= S_IDLE;
            r_matched   <= '0;
            r_pos       <= '0;
            r_answer    <= 1'b0;
            r_out_valid <= n_out_valid;
        end else begin
            r_state     <= n_state;
            r_matched   <= n_matched;
            r_pos       <= n_pos;
            r_answer    <= n_answer;
            r_out_valid <= n_out_valid;
        end
        r_jp1       <= n_jp1;
        r_c         <= n_c;
        r_last      <= n_last;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out_found;
    assign o_result.match_index = r_out_index;

    `KMP_ASSERT_IMPL(a_answer_no_partial, r_answer, r_matched == '0)
    `KMP_ASSERT(a_matched_short, i_ctrl.clear || r_matched < i_len || r_matched == '0)
    `KMP_ASSERT_IMPL(a_scan_bounded, r_state == S_SCAN, r_jp1 <= i_len && !i_ctrl.busy)
    `KMP_ASSERT_IMPL(a_out_free_at_scan, r_state == S_SCAN, !r_out_valid)

endmodule
`default_nettype wire

// File: rtl/core/kmp_substring_search.sv
// ----------------------------------------------------------------------------
// kmp_substring_search
// Streaming first-occurrence substring search with a pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Write the pattern through the register port (index 0: bytes 0-7, index 1:
//   bytes 8-15, index 2: length). Each write rebuilds the failure table, and
//   the text channel is held off while the table is being rebuilt.
//   Text words carry one byte and a last-byte flag. One result word is given
//   per text: found with the start offset of the first match, or not found
//   on the last byte. Bytes after a match give nothing; the last byte
//   restarts the search.
//   The deciding byte leaves the queue and is compared in the scan state,
//   which follows one failure link per mismatch before the result word is
//   registered. The engine takes no new byte until it has finished the last one.
//   A two-word input queue decouples the text channel from the engine.
//   Reset clears the search state and the pattern, then builds the table for
//   an empty pattern before the first word is taken.
//   When the result receiver stalls, a pending result word holds the engine
//   before its next byte, the input queue fills, then ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module kmp_substring_search
    import kmp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [CFG_BITS-1:0]  i_cfg_data,
    kmp_text_if.sink            i_text,
    kmp_result_if.source        o_result
);

    t_ctrl    ctrl;
    t_pattern pattern;
    t_len     len;
    t_idx     link_addr;
    t_len     link_data;

    kmp_text_if queue_if ();

    kmp_links u_links (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_link_addr (link_addr),
        .o_link_data (link_data),
        .o_pattern   (pattern),
        .o_len       (len),
        .o_ctrl      (ctrl)
    );

    kmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_text  (i_text),
        .o_queue (queue_if.source)
    );

    kmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_pattern   (pattern),
        .i_len       (len),
        .i_link_data (link_data),
        .o_link_addr (link_addr),
        .i_queue     (queue_if.sink),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// File: test/kmp_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_search_checker
// Watches the register port and both word channels of the substring search
// block, tracks the pattern and search state on its own, predicts the answer
// of every text and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module kmp_search_checker
    import kmp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [CFG_BITS-1:0]  i_cfg_data,
    kmp_text_if                 i_text,
    kmp_result_if               i_result,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic                  found;
        logic [MATCH_BITS-1:0] match_index;
    } t_answer;

    t_answer                  answers_due[$];
    logic [63:0]              pat_lo;
    logic [63:0]              pat_hi;
    logic [4:0]               pat_len;
    int                       link_tab[MAX_PATTERN];
    int                       run_len;
    logic [POSITION_BITS-1:0] text_pos;
    bit                       answered;
    int                       errs = 0;

    function automatic t_byte byte_at(input int k);
        if (k < 0 || k >= 16) begin
            return 8'h00;
        end
        if (k < 8) begin
            return pat_lo[8*k +: 8];
        end
        return pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic int used_len();
        return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    endfunction

    task automatic restart_text();
        run_len  = 0;
        text_pos = '0;
        answered = 1'b0;
    endtask

    // optimized failure links: -1 means move on to the next text byte
    task automatic rebuild_links();
        int n;
        int i;
        int j;
        int k;
        n = used_len();
        i = 0;
        j = -1;
        for (k = 0; k < MAX_PATTERN; k++) begin
            link_tab[k] = -1;
        end
        if (n == 0) begin
            return;
        end
        while (i < n - 1) begin
            if (j == -1 || byte_at(i) == byte_at(j)) begin
                i++;
                j++;
                if (byte_at(i) == byte_at(j)) begin
                    link_tab[i] = link_tab[j];
                end else begin
                    link_tab[i] = j;
                end
            end else begin
                j = link_tab[j];
            end
        end
    endtask

    task automatic advance_search(input t_byte c, input logic last);
        int          n;
        int          j;
        logic [31:0] start;
        t_answer     ans;
        n = used_len();
        if (answered) begin
            if (last) begin
                restart_text();
            end
            return;
        end
        if (n == 0) begin
            ans.found       = 1'b1;
            ans.match_index = text_pos[MATCH_BITS-1:0];
            answers_due.push_back(ans);
            if (last) begin
                restart_text();
            end else begin
                answered = 1'b1;
            end
            return;
        end
        j = (run_len >= n) ? 0 : run_len;
        while (j >= 0 && byte_at(j) != c) begin
            j = link_tab[j];
        end
        j++;
        if (j >= n) begin
            start           = 32'(text_pos) + 32'd1 - 32'(n);
            ans.found       = 1'b1;
            ans.match_index = start[MATCH_BITS-1:0];
            answers_due.push_back(ans);
            if (last) begin
                restart_text();
            end else begin
                run_len  = 0;
                answered = 1'b1;
                if (text_pos != '1) begin
                    text_pos++;
                end
            end
            return;
        end
        if (last) begin
            ans.found       = 1'b0;
            ans.match_index = '0;
            answers_due.push_back(ans);
            restart_text();
            return;
        end
        run_len = j;
        if (text_pos != '1) begin
            text_pos++;
        end
    endtask

    task automatic check_word(input logic found, input logic [MATCH_BITS-1:0] idx);
        t_answer want;
        if (answers_due.size() == 0) begin
            $display("%0t: unexpected result word: found=%0b index=%0d", $time, found, idx);
            errs++;
            return;
        end
        want = answers_due.pop_front();
        if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, found);
            errs++;
        end
        if (idx !== want.match_index) begin
            $display("%0t: match_index mismatch: expected %0d, actual %0d",
                     $time, want.match_index, idx);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = '0;
            rebuild_links();
            restart_text();
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAT_LOW:  pat_lo  = i_cfg_data[63:0];
                    CFG_PAT_HIGH: pat_hi  = i_cfg_data[63:0];
                    CFG_PAT_LEN:  pat_len = i_cfg_data[4:0];
                    default: ;
                endcase
                if (i_cfg_index == CFG_PAT_LOW || i_cfg_index == CFG_PAT_HIGH ||
                    i_cfg_index == CFG_PAT_LEN) begin
                    rebuild_links();
                    restart_text();
                end
            end
            if (i_text.valid && i_text.ready) begin
                advance_search(i_text.text_byte, i_text.is_final);
            end
            if (i_result.valid && i_result.ready) begin
                check_word(i_result.found, i_result.match_index);
            end
        end
        o_pending    <= answers_due.size();
        o_fail_count <= errs;
    end

endmodule

// File: test/kmp_substring_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_substring_search_tb
// Drives patterns and texts into the substring search block: a short directed
// run over the corner cases, one longer text with a late match, then random
// phases of pattern writes and texts built mostly from the pattern's own
// bytes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module kmp_substring_search_tb;
    import kmp_pkg::*;

    localparam int WORD_GOAL     = 1580;
    localparam int CALM_WORDS    = 200;
    localparam int SETTLE_CYCLES = 96;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SAT_FILL      = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    kmp_text_if   text_ch();
    kmp_result_if result_ch();

    int    fail_count;
    int    pending;
    int    cycles = 0;
    int    words_sent = 0;
    bit    gaps_on = 1'b0;
    t_byte txt[$];
    t_byte fresh[16];
    t_byte live_pat[16];
    logic [4:0] live_len;

    kmp_substring_search DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_text      (text_ch),
        .o_result    (result_ch)
    );

    kmp_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_text       (text_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result receiver
    initial begin
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic send_word(input t_byte b, input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.is_final  <= last;
        do @(posedge i_clk); while (!text_ch.ready);
        words_sent++;
    endtask

    task automatic send_text(input bit finish);
        int k;
        for (k = 0; k < txt.size(); k++) begin
            send_word(txt[k], finish && (k == txt.size() - 1));
        end
    endtask

    // hold off until every answer is in and the engine has drained
    task automatic settle();
        text_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_pattern(input logic [2:0] mask, input logic [4:0] len);
        logic [63:0] lo_word;
        logic [63:0] hi_word;
        int          k;
        for (k = 0; k < 8; k++) begin
            lo_word[8*k +: 8] = fresh[k];
            hi_word[8*k +: 8] = fresh[k+8];
        end
        if (mask[0]) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PAT_LOW;
            cfg_data  <= lo_word;
            @(posedge i_clk);
            for (k = 0; k < 8; k++) live_pat[k] = fresh[k];
        end
        if (mask[1]) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PAT_HIGH;
            cfg_data  <= hi_word;
            @(posedge i_clk);
            for (k = 8; k < 16; k++) live_pat[k] = fresh[k];
        end
        if (mask[2]) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PAT_LEN;
            cfg_data  <= {32'($urandom), 27'($urandom), len};
            @(posedge i_clk);
            live_len = len;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic make_text();
        int n;
        int eff;
        int pick;
        int cut;
        int k;
        txt.delete();
        n   = $urandom_range(1, 20);
        eff = (live_len > 16) ? 16 : int'(live_len);
        while (txt.size() < n) begin
            pick = $urandom_range(0, 15);
            if (pick < 2 && eff > 0) begin
                cut = (pick == 0) ? eff : $urandom_range(1, eff);
                for (k = 0; k < cut; k++) txt.push_back(live_pat[k]);
            end else if (pick < 13 && eff > 0) begin
                txt.push_back(live_pat[$urandom_range(0, eff - 1)]);
            end else begin
                txt.push_back(t_byte'($urandom));
            end
        end
    endtask

    task automatic random_phase(input bit first);
        t_byte      a0;
        t_byte      a1;
        int         sel;
        int         k;
        int         texts;
        logic [4:0] len;
        logic [2:0] mask;
        a0 = t_byte'($urandom);
        a1 = t_byte'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            a0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            a1 = a0;
        end
        for (k = 0; k < 16; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                fresh[k] = t_byte'($urandom);
            end else begin
                fresh[k] = $urandom_range(0, 1) ? a0 : a1;
            end
        end
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            len = 5'd0;
        end else if (sel == 1) begin
            len = 5'd16;
        end else if (sel == 2) begin
            len = 5'($urandom_range(17, 31));
        end else if (sel < 6) begin
            len = 5'($urandom_range(7, 15));
        end else begin
            len = 5'($urandom_range(1, 6));
        end
        mask = first ? 3'b111 : 3'($urandom_range(1, 7));
        program_pattern(mask, len);
        texts = $urandom_range(1, 4);
        for (k = 0; k < texts; k++) begin
            make_text();
            // an unfinished last text gets aborted by the next register write
            send_text(!(k == texts - 1 && $urandom_range(0, 5) == 0));
        end
        settle();
    endtask

    initial begin
        int base;
        int k;
        bit first;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_PAT_LOW;
        cfg_data          <= '0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.is_final  <= 1'b0;
        for (k = 0; k < 16; k++) live_pat[k] = 8'h00;
        live_len = 5'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern straight out of reset
        txt = '{8'h00, 8'hFF, 8'h5A};
        send_text(1'b1);
        txt = '{8'hFF};
        send_text(1'b1);
        settle();

        for (k = 0; k < 16; k++) fresh[k] = 8'hFF;
        fresh[0] = 8'h00;
        fresh[1] = 8'hFF;
        fresh[2] = 8'h00;
        fresh[3] = 8'hFF;
        fresh[4] = 8'h80;
        program_pattern(3'b111, 5'd5);
        txt = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80, 8'h00};
        send_text(1'b1);
        txt = '{8'h00, 8'hFF, 8'h80};
        send_text(1'b1);
        txt = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
        send_text(1'b1);
        settle();

        // oversized length register
        for (k = 0; k < 16; k++) fresh[k] = 8'h00;
        program_pattern(3'b111, 5'd31);
        txt = '{8'h00, 8'h00};
        send_text(1'b1);
        settle();

        // one longer text with the match near its end
        fresh[0] = 8'h01;
        fresh[1] = 8'h02;
        fresh[2] = 8'h03;
        program_pattern(3'b101, 5'd3);
        for (k = 0; k < SAT_FILL; k++) send_word(8'h00, 1'b0);
        txt = '{8'h01, 8'h02, 8'h03};
        send_text(1'b1);
        settle();

        base  = words_sent;
        first = 1'b1;
        while (words_sent - base < WORD_GOAL) begin
            gaps_on = (words_sent - base < WORD_GOAL - CALM_WORDS) &&
                      ($urandom_range(0, 3) != 0);
            random_phase(first);
            first = 1'b0;
        end
        gaps_on = 1'b0;
        settle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
